>>> rtl/rcot_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcot_pkg: shared constants and types for the range count ones tree.
// Holds tree sizing, bus widths and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package rcot_pkg;

   localparam int POSITIONS  = 1024;
   localparam int MEM_DEPTH  = 2 * POSITIONS;
   localparam int ADDR_W     = $clog2(MEM_DEPTH);
   localparam int PTR_W      = ADDR_W + 1;
   localparam int IDX_W      = 11;
   localparam int VAL_W      = 32;
   localparam int CNT_W      = 11;
   localparam int REQ_DATA_W = ((2 * IDX_W + VAL_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((CNT_W + 7) / 8) * 8;

   localparam logic KIND_SET   = 1'b0;
   localparam logic KIND_COUNT = 1'b1;

   typedef struct packed {
      logic clear_step;
      logic load;
      logic prep;
      logic leaf;
      logic up;
      logic lo_step;
      logic hi_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic kind;
      logic set_valid;
      logic at_root;
      logic lo_lt_hi;
      logic out_full;
   } status_type;

endpackage

>>> rtl/rcot_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcot_ram: generic simple dual-port RAM.
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rcot_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/rcot_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcot_dpath: datapath of the range count ones tree.
// Holds the node memory, the walk pointers, the running sum and the result
// register, and steps them under command from the controller.
// ----------------------------------------------------------------------------
module rcot_dpath (
   input  logic                         clock,
   input  logic                         reset,
   input  rcot_pkg::cmd_type            cmd,
   output rcot_pkg::status_type         status,
   input  logic                         req_kind,
   input  logic [rcot_pkg::IDX_W-1:0]   req_first,
   input  logic [rcot_pkg::IDX_W-1:0]   req_last,
   input  logic [rcot_pkg::VAL_W-1:0]   req_value,
   input  logic                         rsp_tready,
   output logic                         rsp_tvalid,
   output logic [rcot_pkg::CNT_W-1:0]   rsp_count
);
   import rcot_pkg::*;

   logic              kind_ff;
   logic [IDX_W-1:0]  first_ff;
   logic [IDX_W-1:0]  last_ff;
   logic              flag_ff;
   logic [ADDR_W-1:0] node_ff, node_in;
   logic [CNT_W-1:0]  cur_ff, cur_in;
   logic [PTR_W-1:0]  lo_ff, lo_in;
   logic [PTR_W-1:0]  hi_ff, hi_in;
   logic [CNT_W-1:0]  acc_ff, acc_in;
   logic              pend_ff, pend_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [CNT_W-1:0]  out_ff;
   logic              out_valid_ff, out_valid_in;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [CNT_W-1:0]  wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [CNT_W-1:0]  rd_data;

   logic [IDX_W-1:0]  first_c;
   logic [IDX_W-1:0]  last_c;
   logic [CNT_W-1:0]  up_sum;
   logic [CNT_W-1:0]  acc_add;
   logic [PTR_W-1:0]  lo_inc;
   logic [PTR_W-1:0]  hi_dec;

   rcot_ram #(
      .DATA_W (CNT_W),
      .DEPTH  (MEM_DEPTH)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      first_c = (first_ff == '0) ? IDX_W'(1) : first_ff;
      last_c  = (last_ff > IDX_W'(POSITIONS)) ? IDX_W'(POSITIONS) : last_ff;
      up_sum  = cur_ff + rd_data;
      acc_add = pend_ff ? (acc_ff + rd_data) : acc_ff;
      lo_inc  = lo_ff + PTR_W'(1);
      hi_dec  = hi_ff - PTR_W'(1);
   end

   always_comb begin
      node_in      = node_ff;
      cur_in       = cur_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      acc_in       = acc_ff;
      pend_in      = pend_ff;
      clr_in       = clr_ff;
      out_valid_in = out_valid_ff;
      wr_en        = 1'b0;
      wr_addr      = node_ff;
      wr_data      = cur_ff;
      rd_en        = 1'b0;
      rd_addr      = node_ff ^ ADDR_W'(1);

      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end

      if (cmd.clear_step) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_data = '0;
         clr_in  = clr_ff + ADDR_W'(1);
      end

      if (cmd.prep) begin
         node_in = ADDR_W'(POSITIONS - 1) + ADDR_W'(first_ff);
         cur_in  = CNT_W'(flag_ff);
         acc_in  = '0;
         pend_in = 1'b0;
         if (first_c > last_c) begin
            lo_in = '0;
            hi_in = '0;
         end else begin
            lo_in = PTR_W'(POSITIONS - 1) + PTR_W'(first_c);
            hi_in = PTR_W'(POSITIONS) + PTR_W'(last_c);
         end
      end

      if (cmd.leaf) begin
         wr_en   = 1'b1;
         rd_en   = 1'b1;
         node_in = node_ff >> 1;
      end

      if (cmd.up) begin
         wr_en   = 1'b1;
         wr_data = up_sum;
         rd_en   = 1'b1;
         cur_in  = up_sum;
         node_in = node_ff >> 1;
      end

      if (cmd.lo_step) begin
         acc_in  = acc_add;
         pend_in = 1'b0;
         if ((lo_ff < hi_ff) && lo_ff[0]) begin
            rd_en   = 1'b1;
            rd_addr = lo_ff[ADDR_W-1:0];
            lo_in   = lo_inc;
            pend_in = 1'b1;
         end
      end

      if (cmd.hi_step) begin
         acc_in  = acc_add;
         pend_in = hi_ff[0];
         rd_en   = hi_ff[0];
         rd_addr = hi_dec[ADDR_W-1:0];
         lo_in   = lo_ff >> 1;
         hi_in   = hi_ff >> 1;
      end

      if (cmd.finish) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         out_valid_ff <= out_valid_in;
      end
      node_ff <= node_in;
      cur_ff  <= cur_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      acc_ff  <= acc_in;
      pend_ff <= pend_in;
      if (cmd.load) begin
         kind_ff  <= req_kind;
         first_ff <= req_first;
         last_ff  <= req_last;
         flag_ff  <= (req_value == VAL_W'(1));
      end
      if (cmd.finish) begin
         out_ff <= acc_ff;
      end
   end

   always_comb begin
      status.clear_last = (clr_ff == ADDR_W'(MEM_DEPTH - 1));
      status.kind       = kind_ff;
      status.set_valid  = (first_ff != '0) && (first_ff <= IDX_W'(POSITIONS));
      status.at_root    = (node_ff == ADDR_W'(1));
      status.lo_lt_hi   = (lo_ff < hi_ff);
      status.out_full   = out_valid_ff;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_count  = out_ff;

endmodule

>>> rtl/rcot_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcot_ctrl: controller of the range count ones tree.
// Sequences the clearing pass, the leaf-to-root update and the range walk.
// ----------------------------------------------------------------------------
module rcot_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  rcot_pkg::status_type  status,
   output rcot_pkg::cmd_type     cmd
);
   import rcot_pkg::*;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_START = 3'd2;
   localparam logic [2:0] ST_LEAF  = 3'd3;
   localparam logic [2:0] ST_UP    = 3'd4;
   localparam logic [2:0] ST_LO    = 3'd5;
   localparam logic [2:0] ST_HI    = 3'd6;
   localparam logic [2:0] ST_DONE  = 3'd7;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_START;
            end
         end
         ST_START: begin
            cmd.prep = 1'b1;
            if (status.kind == KIND_COUNT) begin
               state_in = ST_LO;
            end else if (status.set_valid) begin
               state_in = ST_LEAF;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_LEAF: begin
            cmd.leaf = 1'b1;
            state_in = ST_UP;
         end
         ST_UP: begin
            cmd.up = 1'b1;
            if (status.at_root) begin
               state_in = ST_IDLE;
            end
         end
         ST_LO: begin
            cmd.lo_step = 1'b1;
            state_in    = status.lo_lt_hi ? ST_HI : ST_DONE;
         end
         ST_HI: begin
            cmd.hi_step = 1'b1;
            state_in    = ST_LO;
         end
         ST_DONE: begin
            if (!status.out_full) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/range_count_ones_tree_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_count_ones_tree_core: segment tree of flag counts, point set and
// range count over 1024 positions.
// Set transactions to a valid position write the node memory once per tree level;
// count transactions walk the tree with a low and a high step per level on the
// single read port, the result appearing in the output register.
// After reset all 2048 node memory entries are cleared, one entry per cycle,
// before the first transaction is accepted.
// ----------------------------------------------------------------------------
module range_count_ones_tree_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tdata: first_index[10:0], last_index[21:11], new_value[53:22], zero fill.
   input  logic [rcot_pkg::REQ_DATA_W-1:0]   req_tdata,
   // tuser: kind.
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tdata: ones_count[10:0], zero fill.
   output logic [rcot_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import rcot_pkg::*;

   cmd_type          cmd;
   status_type       status;
   logic [CNT_W-1:0] rsp_count;

   rcot_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rcot_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_kind   (req_tuser),
      .req_first  (req_tdata[IDX_W-1:0]),
      .req_last   (req_tdata[2*IDX_W-1:IDX_W]),
      .req_value  (req_tdata[2*IDX_W+VAL_W-1:2*IDX_W]),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_count  (rsp_count)
   );

   assign rsp_tdata = RSP_DATA_W'(rsp_count);

endmodule

>>> bench/range_count_ones_tree_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_count_ones_tree_core_test: self-checking bench for the flag count tree.
// Drives set and count transactions with bursty pacing against a stalling
// receiver. A scoreboard mirrors the flags and checks each returned count.
// ----------------------------------------------------------------------------
module range_count_ones_tree_core_test;

   import rcot_pkg::*;

   localparam int RANDOM_ITEMS  = 2000;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 64;
   localparam int REPORT_LIMIT  = 10;
   localparam int INDEX_TOP     = (1 << IDX_W) - 1;

   class flag_count_board;
      bit               flags [1:POSITIONS];
      logic [CNT_W-1:0] expected_counts [$];
      int               sets_seen;
      int               ignored_sets;
      int               counts_seen;
      int               empty_ranges;
      int               results_checked;
      int               mismatches;
      int               unexpected;

      function int count_flags(int first, int last);
         int lo;
         int hi;
         int total;
         lo    = (first < 1) ? 1 : first;
         hi    = (last > POSITIONS) ? POSITIONS : last;
         total = 0;
         if (lo > hi) begin
            empty_ranges++;
            return 0;
         end
         for (int p = lo; p <= hi; p++) begin
            total += flags[p];
         end
         return total;
      endfunction

      function void note_request(logic kind, logic [IDX_W-1:0] first,
                                 logic [IDX_W-1:0] last, logic [VAL_W-1:0] value);
         if (kind == KIND_SET) begin
            sets_seen++;
            if (first >= 1 && first <= POSITIONS) begin
               flags[first] = (value == 1);
            end else begin
               ignored_sets++;
            end
         end else begin
            counts_seen++;
            expected_counts.push_back(CNT_W'(count_flags(first, last)));
         end
      endfunction

      function void check_response(logic [CNT_W-1:0] ones_count);
         logic [CNT_W-1:0] want;
         if (expected_counts.size() == 0) begin
            unexpected++;
            if (mismatches + unexpected <= REPORT_LIMIT) begin
               $display("Unexpected result: ones_count %0d with no count pending.",
                        ones_count);
            end
            return;
         end
         want = expected_counts.pop_front();
         results_checked++;
         if (ones_count !== want) begin
            mismatches++;
            if (mismatches + unexpected <= REPORT_LIMIT) begin
               $display("Mismatch on result %0d: ones_count expected %0d, actual %0d.",
                        results_checked, want, ones_count);
            end
         end
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = KIND_SET;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   flag_count_board board = new();
   int              burst_left = 0;
   int              ready_hold = 0;

   range_count_ones_tree_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_response(rsp_tdata[CNT_W-1:0]);
      end
      if (ready_hold == 0) begin
         case ($urandom_range(0, 9))
            0: begin
               rsp_tready <= 1'b1;
               ready_hold = $urandom_range(100, 300);
            end
            1, 2, 3: begin
               rsp_tready <= 1'b0;
               ready_hold = $urandom_range(1, 12);
            end
            default: begin
               rsp_tready <= 1'b1;
               ready_hold = $urandom_range(1, 20);
            end
         endcase
      end else begin
         ready_hold--;
      end
   end

   task automatic send_item(input logic kind, input logic [IDX_W-1:0] first,
                            input logic [IDX_W-1:0] last, input logic [VAL_W-1:0] value);
      logic [REQ_DATA_W-1:0] word;
      word = '0;
      word[IDX_W-1:0] = first;
      word[2*IDX_W-1:IDX_W] = last;
      word[2*IDX_W+VAL_W-1:2*IDX_W] = value;
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      req_tuser  <= kind;
      do @(posedge clock); while (!req_tready);
      board.note_request(kind, first, last, value);
   endtask

   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 30);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (board.expected_counts.size() != 0) @(posedge clock);
   endtask

   task automatic random_item(output logic kind, output logic [IDX_W-1:0] first,
                              output logic [IDX_W-1:0] last,
                              output logic [VAL_W-1:0] value);
      int pick;
      int span;
      int roll;
      pick  = $urandom_range(0, 99);
      kind  = (pick < 50) ? KIND_SET : KIND_COUNT;
      first = IDX_W'($urandom_range(1, POSITIONS));
      last  = IDX_W'($urandom);
      value = $urandom;
      if (pick < 45) begin
         roll = $urandom_range(0, 19);
         if (roll < 12) begin
            value = 1;
         end else if (roll < 17) begin
            value = 0;
         end
      end else if (pick < 50) begin
         first = $urandom_range(0, 1) ? '0 : IDX_W'($urandom_range(POSITIONS + 1, INDEX_TOP));
         if ($urandom_range(0, 1)) begin
            value = 1;
         end
      end else if (pick < 90) begin
         span = $urandom_range(0, 1) ? 63 : POSITIONS;
         last = IDX_W'($urandom_range(first, (first + span > POSITIONS) ? POSITIONS
                                                                         : first + span));
      end else if (pick < 95) begin
         first = IDX_W'($urandom_range(2, INDEX_TOP));
         last  = IDX_W'($urandom_range(0, first - 1));
      end else begin
         first = $urandom_range(0, 1) ? '0 : IDX_W'($urandom);
         last  = $urandom_range(0, 1) ? IDX_W'($urandom_range(POSITIONS, INDEX_TOP))
                                      : IDX_W'($urandom);
      end
   endtask

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Timeout after %0d cycles.", CYCLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      logic             kind;
      logic [IDX_W-1:0] first;
      logic [IDX_W-1:0] last;
      logic [VAL_W-1:0] value;
      int               failures;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_item(KIND_COUNT, IDX_W'(1), IDX_W'(POSITIONS), 0);
      send_item(KIND_SET, IDX_W'(1), IDX_W'(0), 1);
      send_item(KIND_SET, IDX_W'(POSITIONS), IDX_W'(0), 1);
      send_item(KIND_SET, IDX_W'(512), IDX_W'(0), 1);
      send_item(KIND_SET, IDX_W'(513), IDX_W'(0), 1);
      send_item(KIND_SET, IDX_W'(513), IDX_W'(0), 3);
      send_item(KIND_SET, IDX_W'(512), IDX_W'(0), 32'hFFFF_FFFF);
      send_item(KIND_SET, IDX_W'(512), IDX_W'(0), 1);
      send_item(KIND_SET, IDX_W'(0), IDX_W'(0), 1);
      send_item(KIND_SET, IDX_W'(POSITIONS + 1), IDX_W'(0), 1);
      send_item(KIND_SET, IDX_W'(INDEX_TOP), IDX_W'(INDEX_TOP), 1);
      send_item(KIND_SET, IDX_W'(700), IDX_W'(0), 32'h8000_0001);
      send_item(KIND_SET, IDX_W'(701), IDX_W'(INDEX_TOP), 1);
      send_item(KIND_COUNT, IDX_W'(0), IDX_W'(INDEX_TOP), 32'hFFFF_FFFF);
      send_item(KIND_COUNT, IDX_W'(1), IDX_W'(1), 0);
      send_item(KIND_COUNT, IDX_W'(POSITIONS), IDX_W'(POSITIONS), 0);
      send_item(KIND_COUNT, IDX_W'(POSITIONS), IDX_W'(1), 0);
      send_item(KIND_COUNT, IDX_W'(INDEX_TOP), IDX_W'(0), 0);
      send_item(KIND_COUNT, IDX_W'(0), IDX_W'(0), 0);
      send_item(KIND_COUNT, IDX_W'(POSITIONS + 1), IDX_W'(INDEX_TOP), 0);
      send_item(KIND_COUNT, IDX_W'(2), IDX_W'(POSITIONS - 1), 0);
      send_item(KIND_COUNT, IDX_W'(512), IDX_W'(513), 0);
      send_item(KIND_SET, IDX_W'(1), IDX_W'(0), 0);
      send_item(KIND_COUNT, IDX_W'(1), IDX_W'(POSITIONS), 0);
      wait_drained();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 2) begin
            wait_drained();
         end
         pace_sender();
         random_item(kind, first, last, value);
         send_item(kind, first, last, value);
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (board.expected_counts.size() != 0) begin
         $display("%0d expected counts never arrived.", board.expected_counts.size());
      end
      failures = board.mismatches + board.unexpected + board.expected_counts.size();
      $display("Covered %0d set transactions (%0d out of range) and %0d count transactions",
               board.sets_seen, board.ignored_sets, board.counts_seen);
      $display("(%0d empty ranges); %0d results compared, %0d mismatches, %0d unexpected.",
               board.empty_ranges, board.results_checked, board.mismatches,
               board.unexpected);
      if (failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/rcot_pkg.sv
rtl/rcot_ram.sv
rtl/rcot_dpath.sv
rtl/rcot_ctrl.sv
rtl/range_count_ones_tree_core.sv
bench/range_count_ones_tree_core_test.sv
